/* hw/rtl/lsc_pkg.sv */
// Shared types and constants for the line segment clipper.
// Used by every module of the clipper; depends on nothing else.
package lsc_pkg;

   localparam int COORD_W   = 16;
   localparam int T_FRAC    = 16;
   localparam int DW        = COORD_W + 1;
   localparam int PW        = COORD_W + 2;
   localparam int TW        = T_FRAC + 3;
   localparam int DIV_STEPS = T_FRAC + 1;
   localparam int RW        = DW + 1 + DIV_STEPS;
   localparam int PRODW     = DW + T_FRAC + 1;
   localparam int NUM_EDGES = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX = 2'd3;

   typedef enum logic [1:0] {
      RC_DIV,
      RC_BELOW,
      RC_ABOVE
   } ratio_code_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic [COORD_W-1:0] clipped_start_x;
      logic [COORD_W-1:0] clipped_start_y;
      logic [COORD_W-1:0] clipped_end_x;
      logic [COORD_W-1:0] clipped_end_y;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_min;
      logic [COORD_W-1:0] x_max;
      logic [COORD_W-1:0] y_min;
      logic [COORD_W-1:0] y_max;
   } window_type;

   typedef struct packed {
      logic           skip;
      logic           reject;
      logic           neg;
      ratio_code_type code;
      logic [DW-1:0]  den;
      logic [RW-1:0]  acc;
   } lane_type;

   typedef struct packed {
      logic [COORD_W-1:0]           sx;
      logic [COORD_W-1:0]           sy;
      logic [DW-1:0]                dx;
      logic [DW-1:0]                dy;
      lane_type [NUM_EDGES-1:0]     lane;
   } work_type;

   typedef struct packed {
      logic               ok;
      logic [T_FRAC:0]    t0;
      logic [T_FRAC:0]    t1;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [DW-1:0]      dx;
      logic [DW-1:0]      dy;
   } sel_type;

endpackage

/* hw/rtl/lsc_setup.sv */
// Entry stage: forms the edge pairs and the divider operands of one segment.
// Depends on lsc_pkg.
module lsc_setup (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  lsc_pkg::req_type    in_data,
   input  lsc_pkg::window_type window,
   output logic                out_valid,
   output lsc_pkg::work_type   out_data
);

   logic              valid_ff;
   lsc_pkg::work_type data_ff, data_in;

   logic signed [lsc_pkg::PW-1:0] sxe, sye, dxe, dye;
   logic signed [lsc_pkg::PW-1:0] p [lsc_pkg::NUM_EDGES];
   logic signed [lsc_pkg::PW-1:0] q [lsc_pkg::NUM_EDGES];
   logic signed [lsc_pkg::PW-1:0] num [lsc_pkg::NUM_EDGES];
   logic signed [lsc_pkg::PW-1:0] den [lsc_pkg::NUM_EDGES];

   always_comb begin
      sxe = lsc_pkg::PW'($signed(in_data.start_x));
      sye = lsc_pkg::PW'($signed(in_data.start_y));
      dxe = lsc_pkg::PW'($signed(in_data.end_x)) - sxe;
      dye = lsc_pkg::PW'($signed(in_data.end_y)) - sye;
      p[0] = -dxe;
      q[0] = sxe - lsc_pkg::PW'($signed(window.x_min));
      p[1] = dxe;
      q[1] = lsc_pkg::PW'($signed(window.x_max)) - sxe;
      p[2] = -dye;
      q[2] = sye - lsc_pkg::PW'($signed(window.y_min));
      p[3] = dye;
      q[3] = lsc_pkg::PW'($signed(window.y_max)) - sye;
      data_in.sx = in_data.start_x;
      data_in.sy = in_data.start_y;
      data_in.dx = dxe[lsc_pkg::DW-1:0];
      data_in.dy = dye[lsc_pkg::DW-1:0];
      for (int k = 0; k < lsc_pkg::NUM_EDGES; k++) begin
         num[k] = p[k][lsc_pkg::PW-1] ? -q[k] : q[k];
         den[k] = p[k][lsc_pkg::PW-1] ? -p[k] : p[k];
         data_in.lane[k].skip   = (p[k] == '0);
         data_in.lane[k].reject = (p[k] == '0) && q[k][lsc_pkg::PW-1];
         data_in.lane[k].neg    = p[k][lsc_pkg::PW-1];
         if (num[k][lsc_pkg::PW-1]) begin
            data_in.lane[k].code = lsc_pkg::RC_BELOW;
         end else if (num[k] > den[k]) begin
            data_in.lane[k].code = lsc_pkg::RC_ABOVE;
         end else begin
            data_in.lane[k].code = lsc_pkg::RC_DIV;
         end
         data_in.lane[k].den = den[k][lsc_pkg::DW-1:0];
         data_in.lane[k].acc = (lsc_pkg::RW'(num[k][lsc_pkg::DW-1:0]) << lsc_pkg::T_FRAC)
                             + lsc_pkg::RW'(den[k][lsc_pkg::DW-1:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/lsc_div_cell.sv */
// One cell of the divider chain: one restoring quotient step on every edge.
// Depends on lsc_pkg.
module lsc_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  lsc_pkg::work_type in_data,
   output logic              out_valid,
   output lsc_pkg::work_type out_data
);

   logic              valid_ff;
   lsc_pkg::work_type data_ff, data_in;

   logic [lsc_pkg::DW:0] part [lsc_pkg::NUM_EDGES];
   logic [lsc_pkg::DW:0] diff [lsc_pkg::NUM_EDGES];
   logic                 ge   [lsc_pkg::NUM_EDGES];

   always_comb begin
      data_in = in_data;
      for (int k = 0; k < lsc_pkg::NUM_EDGES; k++) begin
         part[k] = {in_data.lane[k].acc[lsc_pkg::RW-2:lsc_pkg::DIV_STEPS],
                    in_data.lane[k].acc[lsc_pkg::DIV_STEPS-1]};
         ge[k]   = part[k] >= {1'b0, in_data.lane[k].den};
         diff[k] = ge[k] ? part[k] - {1'b0, in_data.lane[k].den} : part[k];
         data_in.lane[k].acc = {diff[k], in_data.lane[k].acc[lsc_pkg::DIV_STEPS-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/lsc_select.sv */
// Folds the ratios of all edges into the entry and exit parameters.
// Depends on lsc_pkg.
module lsc_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  lsc_pkg::work_type in_data,
   output logic              out_valid,
   output lsc_pkg::sel_type  out_data
);

   localparam logic signed [lsc_pkg::TW-1:0] T_ONE =
      lsc_pkg::TW'(1) << lsc_pkg::T_FRAC;

   logic             valid_ff;
   lsc_pkg::sel_type data_ff, data_in;

   logic signed [lsc_pkg::TW-1:0] r [lsc_pkg::NUM_EDGES];
   logic signed [lsc_pkg::TW-1:0] t0, t1;
   logic                          ok;

   always_comb begin
      t0 = '0;
      t1 = T_ONE;
      ok = 1'b1;
      for (int k = 0; k < lsc_pkg::NUM_EDGES; k++) begin
         case (in_data.lane[k].code)
            lsc_pkg::RC_DIV:   r[k] = lsc_pkg::TW'(in_data.lane[k].acc[lsc_pkg::DIV_STEPS-1:0]);
            lsc_pkg::RC_ABOVE: r[k] = T_ONE + lsc_pkg::TW'(1);
            default:           r[k] = '1;
         endcase
         if (ok) begin
            if (in_data.lane[k].skip) begin
               if (in_data.lane[k].reject) begin
                  ok = 1'b0;
               end
            end else if (in_data.lane[k].neg) begin
               if (r[k] > t1) begin
                  ok = 1'b0;
               end else if (r[k] > t0) begin
                  t0 = r[k];
               end
            end else begin
               if (r[k] < t0) begin
                  ok = 1'b0;
               end else if (r[k] < t1) begin
                  t1 = r[k];
               end
            end
         end
      end
      data_in.ok = ok;
      data_in.t0 = t0[lsc_pkg::T_FRAC:0];
      data_in.t1 = t1[lsc_pkg::T_FRAC:0];
      data_in.sx = in_data.sx;
      data_in.sy = in_data.sy;
      data_in.dx = in_data.dx;
      data_in.dy = in_data.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/lsc_interp.sv */
// Computes the clipped endpoints from the parameters: multiply, then round and add.
// Depends on lsc_pkg; holds the result register of the block.
module lsc_interp (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  lsc_pkg::sel_type in_data,
   output logic             out_valid,
   output lsc_pkg::rsp_type out_data
);

   localparam int OW = lsc_pkg::DW + 2;
   localparam logic [lsc_pkg::PRODW:0] HALF = (lsc_pkg::PRODW + 1)'(1) << (lsc_pkg::T_FRAC - 1);

   logic                       mul_valid_ff;
   logic                       ok_ff, neg_x_ff, neg_y_ff;
   logic [lsc_pkg::COORD_W-1:0] sx_ff, sy_ff;
   logic [lsc_pkg::PRODW-1:0]   prod_ff [4];
   logic [lsc_pkg::PRODW-1:0]   prod_in [4];
   logic [lsc_pkg::DW-1:0]      mag_x, mag_y;

   logic             valid_ff;
   lsc_pkg::rsp_type data_ff, data_in;

   logic [lsc_pkg::PRODW:0]  rounded [4];
   logic signed [OW-1:0]     off     [4];
   logic signed [OW-1:0]     res     [4];
   logic signed [OW-1:0]     sxe, sye;

   always_comb begin
      mag_x = in_data.dx[lsc_pkg::DW-1] ? -in_data.dx : in_data.dx;
      mag_y = in_data.dy[lsc_pkg::DW-1] ? -in_data.dy : in_data.dy;
      prod_in[0] = lsc_pkg::PRODW'(mag_x) * lsc_pkg::PRODW'(in_data.t0);
      prod_in[1] = lsc_pkg::PRODW'(mag_y) * lsc_pkg::PRODW'(in_data.t0);
      prod_in[2] = lsc_pkg::PRODW'(mag_x) * lsc_pkg::PRODW'(in_data.t1);
      prod_in[3] = lsc_pkg::PRODW'(mag_y) * lsc_pkg::PRODW'(in_data.t1);
   end

   always_comb begin
      sxe = OW'($signed(sx_ff));
      sye = OW'($signed(sy_ff));
      for (int k = 0; k < 4; k++) begin
         rounded[k] = {1'b0, prod_ff[k]} + HALF;
         off[k]     = OW'(rounded[k] >> lsc_pkg::T_FRAC);
      end
      res[0] = neg_x_ff ? sxe - off[0] : sxe + off[0];
      res[1] = neg_y_ff ? sye - off[1] : sye + off[1];
      res[2] = neg_x_ff ? sxe - off[2] : sxe + off[2];
      res[3] = neg_y_ff ? sye - off[3] : sye + off[3];
      data_in.visible         = ok_ff;
      data_in.clipped_start_x = ok_ff ? res[0][lsc_pkg::COORD_W-1:0] : '0;
      data_in.clipped_start_y = ok_ff ? res[1][lsc_pkg::COORD_W-1:0] : '0;
      data_in.clipped_end_x   = ok_ff ? res[2][lsc_pkg::COORD_W-1:0] : '0;
      data_in.clipped_end_y   = ok_ff ? res[3][lsc_pkg::COORD_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= in_valid;
         valid_ff     <= mul_valid_ff;
      end
      if (advance) begin
         ok_ff    <= in_data.ok;
         neg_x_ff <= in_data.dx[lsc_pkg::DW-1];
         neg_y_ff <= in_data.dy[lsc_pkg::DW-1];
         sx_ff    <= in_data.sx;
         sy_ff    <= in_data.sy;
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         data_ff  <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/line_segment_clipper_unit.sv */
// Top level of the line segment clipper: window registers and the cell pipeline.
// Depends on lsc_pkg, lsc_setup, lsc_div_cell, lsc_select and lsc_interp.
//
// Segments enter on the req_ channel as one beat each and leave on the rsp_
// channel as one beat each, in order, with a visible flag and the clipped
// endpoints. The user must write the window edges through the csr_ port only
// while the block is idle; the block does not enforce this. Reset loads the
// widest possible window. The block takes one beat per cycle while it is not
// stalled. It has one setup stage, a chain of 17 divider cells that each
// produce one quotient bit of every edge ratio, one stage that folds the
// ratios into the entry and exit parameters, one multiply stage and the
// result register. When the receiver stalls a waiting result, the whole
// pipeline holds and req_stall rises in the same cycle; it falls as soon as
// the result is taken. Reset empties the pipeline and drops rsp_valid.
module line_segment_clipper_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lsc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lsc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [lsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsc_pkg::COORD_W-1:0]      csr_data
);

   lsc_pkg::window_type window_ff;
   logic                advance;

   logic              stage_valid [lsc_pkg::DIV_STEPS+1];
   lsc_pkg::work_type stage_data  [lsc_pkg::DIV_STEPS+1];
   logic              sel_valid;
   lsc_pkg::sel_type  sel_data;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.x_min <= {1'b1, {(lsc_pkg::COORD_W-1){1'b0}}};
         window_ff.x_max <= {1'b0, {(lsc_pkg::COORD_W-1){1'b1}}};
         window_ff.y_min <= {1'b1, {(lsc_pkg::COORD_W-1){1'b0}}};
         window_ff.y_max <= {1'b0, {(lsc_pkg::COORD_W-1){1'b1}}};
      end else if (csr_we) begin
         case (csr_index)
            lsc_pkg::CSR_X_MIN: window_ff.x_min <= csr_data;
            lsc_pkg::CSR_X_MAX: window_ff.x_max <= csr_data;
            lsc_pkg::CSR_Y_MIN: window_ff.y_min <= csr_data;
            lsc_pkg::CSR_Y_MAX: window_ff.y_max <= csr_data;
            default: ;
         endcase
      end
   end

   lsc_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .window    (window_ff),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < lsc_pkg::DIV_STEPS; i++) begin : g_cell
      lsc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   lsc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (stage_valid[lsc_pkg::DIV_STEPS]),
      .in_data   (stage_data[lsc_pkg::DIV_STEPS]),
      .out_valid (sel_valid),
      .out_data  (sel_data)
   );

   lsc_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sel_valid),
      .in_data   (sel_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
